FILE: design/bitmap_block_allocator_macros.svh
// Assertion macros for the bitmap block allocator.
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bba_pkg.sv
// Shared constants, codes and control structs of the bitmap block allocator.
`default_nettype none

package bba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_BITS  = 32;
    localparam int MAP_WORDS  = MAX_BLOCKS / WORD_BITS;

    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(MAP_WORDS);
    localparam int WC_W       = WADDR_W + 1;
    localparam int BLK_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = BLK_W + 1;
    localparam int SUM_W      = CNT_W + 1;

    localparam int OP_W       = 2;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'd1;

    localparam logic [CNT_W-1:0] TOTAL_RESET    = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] RESERVED_RESET = CNT_W'(1);

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MARK  = 2'd2,
        OP_INIT  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_NOFIT = 2'd1,
        ST_BAD   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SW_SEARCH = 2'd0,
        SW_MARK   = 2'd1,
        SW_INIT   = 2'd2
    } sweep_t;

    // controller -> datapath
    typedef struct packed {
        logic    load_req;
        logic    setup;
        logic    issue;
        logic    init_write;
        logic    finish;
        sweep_t  sweep;
        status_t code;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic req_bad;
        logic rd_more;
        logic pv;
        logic found;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/bba_if.sv
// Request and result channel interfaces of the bitmap block allocator.
`default_nettype none

interface bba_req_if import bba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [BLK_W-1:0]  start_block;
    logic [CNT_W-1:0]  block_count;

    modport source (output valid, operation, start_block, block_count, input ready);
    modport sink   (input valid, operation, start_block, block_count, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*;;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  granted_block;
    logic [CNT_W-1:0]  free_blocks;

    modport source (output valid, status, granted_block, free_blocks, input ready);
    modport sink   (input valid, status, granted_block, free_blocks, output ready);
endinterface

`default_nettype wire

FILE: design/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/bba_ctrl.sv
// Sequencer for the allocator: request check, map sweeps and result hand-off.
`default_nettype none

module bba_ctrl import bba_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output      logic     in_ready,
    output      logic     out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output      dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_MARK,
        S_INIT,
        S_DONE
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.code   = code_reg;
        case (state_reg)
            S_SEARCH: cmd.sweep = SW_SEARCH;
            S_INIT:   cmd.sweep = SW_INIT;
            default:  cmd.sweep = SW_MARK;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.req_bad)
                begin
                    code_next  = ST_BAD;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.setup = 1'b1;
                    case (stat.op)
                        OP_INIT:  state_next = S_INIT;
                        OP_ALLOC: state_next = S_SEARCH;
                        default:  state_next = S_MARK;
                    endcase
                end
            end
            S_SEARCH:
            begin
                cmd.issue = stat.rd_more && !stat.found;
                if (stat.found)
                begin
                    state_next = S_MARK;
                end
                else if (!stat.rd_more && !stat.pv)
                begin
                    code_next  = ST_NOFIT;
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                cmd.issue = stat.rd_more;
                if (!stat.rd_more && !stat.pv)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_INIT:
            begin
                cmd.init_write = stat.rd_more;
                if (!stat.rd_more)
                begin
                    code_next  = ST_OK;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: design/bba_dp.sv
// Allocator datapath: config, request latch, usage map RAM, run search and marking.
`default_nettype none

module bba_dp import bba_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [OP_W-1:0]       req_operation,
    input  wire logic [BLK_W-1:0]      req_start,
    input  wire logic [CNT_W-1:0]      req_count,
    input  wire dp_cmd_t               cmd,
    output      dp_stat_t              stat,
    output      logic [STAT_W-1:0]     rsp_status,
    output      logic [BLK_W-1:0]      rsp_granted,
    output      logic [CNT_W-1:0]      rsp_free
);

    // control state
    logic [CNT_W-1:0]     total_reg, total_next;
    logic [CNT_W-1:0]     reserved_reg, reserved_next;
    logic [WC_W-1:0]      wc_reg, wc_next;
    logic                 pv_reg, pv_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [MAP_WORDS-1:0] valid_reg, valid_next;

    // payload
    op_t                  op_reg, op_next;
    logic [BLK_W-1:0]     start_reg, start_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BLK_W-1:0]     first_reg, first_next;
    logic [BLK_W-1:0]     last_reg, last_next;
    logic                 empty_reg, empty_next;
    logic [WADDR_W-1:0]   pw_reg, pw_next;
    logic [CNT_W-1:0]     run_reg, run_next;
    logic [BLK_W-1:0]     granted_reg, granted_next;
    status_t              status_reg, status_next;
    logic [BLK_W-1:0]     out_granted_reg, out_granted_next;
    logic [CNT_W-1:0]     free_reg, free_next;

    logic [CNT_W-1:0]     eff_total;
    logic [CNT_W-1:0]     total_m1;
    logic [SUM_W-1:0]     end_sum;
    logic [SUM_W-1:0]     end_m1;
    logic                 req_bad;
    logic [WADDR_W-1:0]   end_w;
    logic                 rd_more;

    logic [WORD_BITS-1:0] ram_q;
    logic [WORD_BITS-1:0] word_in;
    logic [WORD_BITS-1:0] beyond;
    logic [WORD_BITS-1:0] word_s;
    logic [SUM_W-1:0]     runlen [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;
    logic                 hit_now;
    logic [BIT_W-1:0]     hit_p;
    logic [BLK_W-1:0]     hit_block;
    logic [CNT_W-1:0]     granted_sum;

    logic [WADDR_W-1:0]   w_sel;
    logic                 in_span;
    logic [BIT_W-1:0]     lo_bit;
    logic [BIT_W-1:0]     hi_bit;
    logic [WORD_BITS-1:0] rmask;
    logic                 set_bits;
    logic [WORD_BITS-1:0] mark_word;
    logic [WORD_BITS-1:0] changed;
    logic [CNT_W-1:0]     delta;

    logic                 ram_we;
    logic [WADDR_W-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    // request check
    assign eff_total = (total_reg > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_reg;
    assign total_m1  = eff_total - CNT_W'(1);
    assign end_sum   = SUM_W'(start_reg) + SUM_W'(count_reg);
    assign end_m1    = end_sum - SUM_W'(1);

    always_comb
    begin
        case (op_reg)
            OP_ALLOC: req_bad = (count_reg == '0) || (count_reg > eff_total);
            OP_INIT:  req_bad = 1'b0;
            default:  req_bad = (count_reg == '0) || (end_sum > SUM_W'(eff_total));
        endcase
    end

    // sweep bounds
    always_comb
    begin
        case (cmd.sweep)
            SW_SEARCH: end_w = total_m1[BLK_W-1:BIT_W];
            SW_MARK:   end_w = last_reg[BLK_W-1:BIT_W];
            default:   end_w = WADDR_W'(MAP_WORDS - 1);
        endcase
    end

    assign rd_more = (wc_reg <= {1'b0, end_w});

    // words never written still read as all used
    assign word_in = valid_reg[pw_reg] ? ram_q : '1;

    // first-fit evaluation of one word; blocks at or past the total count as used
    always_comb
    begin
        logic [BIT_W-1:0] u;
        logic             any;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            beyond[i] = (pw_reg == total_m1[BLK_W-1:BIT_W]) &&
                        (BIT_W'(i) > total_m1[BIT_W-1:0]);
        end
        word_s = word_in | beyond;
        for (int p = 0; p < WORD_BITS; p++)
        begin
            u   = '0;
            any = 1'b0;
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if ((j <= p) && word_s[j])
                begin
                    any = 1'b1;
                    u   = BIT_W'(j);
                end
            end
            runlen[p]  = any ? (SUM_W'(p) - SUM_W'(u))
                             : (SUM_W'(run_reg) + SUM_W'(p) + SUM_W'(1));
            hit_vec[p] = (runlen[p] >= SUM_W'(count_reg));
        end
        hit_p = '0;
        for (int p = WORD_BITS - 1; p >= 0; p--)
        begin
            if (hit_vec[p])
            begin
                hit_p = BIT_W'(p);
            end
        end
    end

    assign hit_now     = pv_reg && (cmd.sweep == SW_SEARCH) && (|hit_vec);
    assign hit_block   = {pw_reg, hit_p};
    assign granted_sum = CNT_W'(hit_block) + CNT_W'(1) - count_reg;

    // span mask of the current run (or init free range) within one word
    assign w_sel   = (cmd.sweep == SW_INIT) ? wc_reg[WADDR_W-1:0] : pw_reg;
    assign in_span = !empty_reg &&
                     (w_sel >= first_reg[BLK_W-1:BIT_W]) &&
                     (w_sel <= last_reg[BLK_W-1:BIT_W]);
    assign lo_bit  = (w_sel == first_reg[BLK_W-1:BIT_W]) ? first_reg[BIT_W-1:0] : '0;
    assign hi_bit  = (w_sel == last_reg[BLK_W-1:BIT_W]) ? last_reg[BIT_W-1:0] : '1;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            rmask[i] = in_span && (BIT_W'(i) >= lo_bit) && (BIT_W'(i) <= hi_bit);
        end
    end

    assign set_bits  = (op_reg != OP_FREE);
    assign mark_word = set_bits ? (word_in | rmask) : (word_in & ~rmask);
    assign changed   = set_bits ? (rmask & ~word_in) : (rmask & word_in);
    assign delta     = CNT_W'($countones((cmd.sweep == SW_INIT) ? rmask : changed));

    assign ram_we    = (pv_reg && (cmd.sweep == SW_MARK)) || cmd.init_write;
    assign ram_waddr = (cmd.sweep == SW_INIT) ? wc_reg[WADDR_W-1:0] : pw_reg;
    assign ram_wdata = (cmd.sweep == SW_INIT) ? ~rmask : mark_word;

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.issue),
        .raddr (wc_reg[WADDR_W-1:0]),
        .rdata (ram_q)
    );

    always_comb
    begin
        total_next       = total_reg;
        reserved_next    = reserved_reg;
        wc_next          = wc_reg;
        pv_next          = 1'b0;
        found_next       = found_reg;
        used_next        = used_reg;
        valid_next       = valid_reg;
        op_next          = op_reg;
        start_next       = start_reg;
        count_next       = count_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        empty_next       = empty_reg;
        pw_next          = pw_reg;
        run_next         = run_reg;
        granted_next     = granted_reg;
        status_next      = status_reg;
        out_granted_next = out_granted_reg;
        free_next        = free_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TOTAL:    total_next    = CNT_W'(cfg_data);
                CFG_RESERVED: reserved_next = CNT_W'(cfg_data);
                default:      ;
            endcase
        end

        if (cmd.load_req)
        begin
            op_next      = op_t'(req_operation);
            start_next   = req_start;
            count_next   = req_count;
            found_next   = 1'b0;
            granted_next = '0;
        end

        if (cmd.setup)
        begin
            run_next = '0;
            case (op_reg)
                OP_ALLOC:
                begin
                    wc_next = '0;
                end
                OP_INIT:
                begin
                    first_next = reserved_reg[BLK_W-1:0];
                    last_next  = total_m1[BLK_W-1:0];
                    empty_next = (reserved_reg >= eff_total);
                    wc_next    = '0;
                    used_next  = CNT_W'(MAX_BLOCKS);
                end
                default:
                begin
                    first_next = start_reg;
                    last_next  = end_m1[BLK_W-1:0];
                    empty_next = 1'b0;
                    wc_next    = WC_W'(start_reg[BLK_W-1:BIT_W]);
                end
            endcase
        end

        if (cmd.issue)
        begin
            wc_next = wc_reg + WC_W'(1);
            pv_next = !hit_now;
            pw_next = wc_reg[WADDR_W-1:0];
        end

        if (pv_reg && (cmd.sweep == SW_SEARCH))
        begin
            if (hit_now)
            begin
                // run found: switch the sweep over to marking it
                found_next   = 1'b1;
                granted_next = granted_sum[BLK_W-1:0];
                first_next   = granted_sum[BLK_W-1:0];
                last_next    = hit_block;
                empty_next   = 1'b0;
                wc_next      = WC_W'(granted_sum[BLK_W-1:BIT_W]);
            end
            else
            begin
                run_next = runlen[WORD_BITS-1][CNT_W-1:0];
            end
        end

        if (pv_reg && (cmd.sweep == SW_MARK))
        begin
            used_next = set_bits ? (used_reg + delta) : (used_reg - delta);
        end

        if (cmd.init_write)
        begin
            wc_next   = wc_reg + WC_W'(1);
            used_next = used_reg - delta;
        end

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        if (cmd.finish)
        begin
            status_next      = cmd.code;
            out_granted_next = granted_reg;
            free_next        = CNT_W'(MAX_BLOCKS) - used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= TOTAL_RESET;
            reserved_reg <= RESERVED_RESET;
            wc_reg       <= '0;
            pv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            used_reg     <= CNT_W'(MAX_BLOCKS);
            valid_reg    <= '0;
        end
        else
        begin
            total_reg    <= total_next;
            reserved_reg <= reserved_next;
            wc_reg       <= wc_next;
            pv_reg       <= pv_next;
            found_reg    <= found_next;
            used_reg     <= used_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        start_reg       <= start_next;
        count_reg       <= count_next;
        first_reg       <= first_next;
        last_reg        <= last_next;
        empty_reg       <= empty_next;
        pw_reg          <= pw_next;
        run_reg         <= run_next;
        granted_reg     <= granted_next;
        status_reg      <= status_next;
        out_granted_reg <= out_granted_next;
        free_reg        <= free_next;
    end

    assign stat.op      = op_reg;
    assign stat.req_bad = req_bad;
    assign stat.rd_more = rd_more;
    assign stat.pv      = pv_reg;
    assign stat.found   = found_reg;

    assign rsp_status  = status_reg;
    assign rsp_granted = out_granted_reg;
    assign rsp_free    = free_reg;

endmodule

`default_nettype wire

FILE: design/bitmap_block_allocator.sv
// Bitmap block allocator top level: first-fit run allocation over a 4096-block usage map.
// One request in flight at a time; the next is taken while the previous result waits
//   in the output register. Sweeps move one map word a cycle through the RAM.
// Reset clears control state, sets total_blocks 4096, reserved_blocks 1, and marks the whole
//   map used through per-word valid bits; no clearing pass, requests are taken at once.
`default_nettype none
`include "bitmap_block_allocator_macros.svh"

module bitmap_block_allocator import bba_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bba_req_if.sink                    req,
    bba_rsp_if.source                  rsp,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Controller: request check, then, unless it fails, the sweeps the op needs:
    // search (stream reads, first-fit run tracking), mark (read-modify-write
    // over the run's words), init (write every word). The result item waits
    // in the output register so the next item can be taken meanwhile.
    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: config registers, usage map RAM with valid bits, the per-word
    // run evaluator, span masks, used-block counter and the result register.
    bba_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_operation (req.operation),
        .req_start     (req.start_block),
        .req_count     (req.block_count),
        .cmd           (cmd),
        .stat          (stat),
        .rsp_status    (rsp.status),
        .rsp_granted   (rsp.granted_block),
        .rsp_free      (rsp.free_blocks)
    );

    // A start block is only reported for a successful allocation.
    `BBA_ASSERT(a_grant_only_ok, rsp.valid && (rsp.status != ST_OK), rsp.granted_block == '0, "granted block set on a failed request")
    // No sweep activity while waiting for a new item.
    `BBA_ASSERT(a_idle_quiet, req.ready, !cmd.issue && !cmd.init_write && !cmd.setup, "map sweep active while idle")
    // The result register is only loaded when it is free or being drained.
    `BBA_ASSERT(a_finish_room, cmd.finish, !rsp.valid || rsp.ready, "result overwritten before taken")
    // An accepted item is worked on before another is taken.
    `BBA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready, "second item taken while busy")

endmodule

`default_nettype wire

FILE: tb/bitmap_block_allocator_tb.sv
// Self-checking testbench for the first-fit bitmap block allocator.
`timescale 1ns / 1ps

module bitmap_block_allocator_tb;
    import bba_pkg::*;

    localparam int IDLE_PCT    = 22;          // chance of a gap per cycle on either side
    localparam int HOLD_CYCLES = 600;         // long result stall, longer than any latency
    localparam int TAIL_CYCLES = 300;         // worst allocate latency plus margin
    localparam int MAX_PRINTS  = 40;

    // one predicted result
    typedef struct {
        status_t              status;
        logic [BLK_W-1:0]     granted;
        logic [CNT_W-1:0]     free_cnt;
    } alloc_result_t;

    // a run handed out by allocate, kept as a hint for later frees
    typedef struct {
        int first;
        int len;
    } block_run_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the block: usage bits (1 = used), used count, both registers.
    logic [MAX_BLOCKS-1:0] usage_bits;
    int                    used_blocks;
    int                    total_reg;
    int                    reserved_reg;

    alloc_result_t awaited_results[$];
    block_run_t    granted_runs[$];
    int            errors;
    bit            quiet;           // no gaps on either side
    int            hold_cycles;     // result-side hold-off, counted down by the ready process

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit: far beyond 600 worst-case allocates with all stalls.
    initial
    begin
        #20_000_000;
        $display("FAIL bitmap_block_allocator");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Mirror of the allocator
    // ---------------------------------------------------------------------

    // Totals beyond the map size behave as the full map.
    function automatic int effective_total();
        return (total_reg > MAX_BLOCKS) ? MAX_BLOCKS : total_reg;
    endfunction

    // Used count only follows bits that really flip.
    function automatic void take_block(int b);
        if (!usage_bits[b])
        begin
            usage_bits[b] = 1'b1;
            used_blocks++;
        end
    endfunction

    function automatic void release_block(int b);
        if (usage_bits[b])
        begin
            usage_bits[b] = 1'b0;
            used_blocks--;
        end
    endfunction

    // Applies one request to the mirror and returns the result it must give.
    function automatic alloc_result_t apply_request(op_t op, logic [BLK_W-1:0] start,
                                                    logic [CNT_W-1:0] count);
        alloc_result_t res;
        block_run_t    run;
        int            lim;
        int            n;
        int            s;
        int            b;
        int            streak;
        int            hit;
        lim = effective_total();
        n   = count;
        s   = start;
        res.status  = ST_OK;
        res.granted = '0;
        case (op)
            OP_INIT:
            begin
                // start and count are don't-care here
                usage_bits  = '1;
                used_blocks = MAX_BLOCKS;
                for (b = reserved_reg; b < lim; b++)
                    release_block(b);
                granted_runs.delete();
            end
            OP_ALLOC:
            begin
                if (n == 0 || n > lim)
                    res.status = ST_BAD;
                else
                begin
                    // lowest run of n clear bits lying wholly below the total
                    streak = 0;
                    hit    = -1;
                    for (b = 0; b < lim && hit < 0; b++)
                    begin
                        streak = usage_bits[b] ? 0 : streak + 1;
                        if (streak == n)
                            hit = b + 1 - n;
                    end
                    if (hit < 0)
                        res.status = ST_NOFIT;
                    else
                    begin
                        for (b = hit; b < hit + n; b++)
                            take_block(b);
                        res.granted = BLK_W'(hit);
                        run.first   = hit;
                        run.len     = n;
                        granted_runs.push_back(run);
                    end
                end
            end
            default:
            begin
                // free and mark-used share the range check
                if (n == 0 || s + n > lim)
                    res.status = ST_BAD;
                else
                    for (b = s; b < s + n; b++)
                        if (op == OP_FREE)
                            release_block(b);
                        else
                            take_block(b);
            end
        endcase
        res.free_cnt = CNT_W'(MAX_BLOCKS - used_blocks);
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, msg);
    endtask

    // Each result taken from the block is compared with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_results.size() == 0)
                report_mismatch("result with no request outstanding");
            else
            begin
                want = awaited_results.pop_front();
                if (rsp_ch.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              rsp_ch.status, want.status));
                if (rsp_ch.granted_block !== want.granted)
                    report_mismatch($sformatf("granted_block %0d, want %0d",
                                              rsp_ch.granted_block, want.granted));
                if (rsp_ch.free_blocks !== want.free_cnt)
                    report_mismatch($sformatf("free_blocks %0d, want %0d",
                                              rsp_ch.free_blocks, want.free_cnt));
            end
        end
    end

    // Result-side ready: long hold when asked, otherwise random gaps unless quiet.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cycles--;
            end
            else if (quiet)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------------

    // Offers one item and returns on the edge that takes it. valid is left high
    // so a back-to-back item needs no second assignment in the same step; the
    // next gap, send or idle wait drops it.
    task automatic send_req(op_t op, int start, int count);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.start_block <= BLK_W'(start);
        req_ch.block_count <= CNT_W'(count);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        awaited_results.push_back(apply_request(op, BLK_W'(start), CNT_W'(count)));
    endtask

    // Sender stops and waits until every result has come back.
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        if (idx == CFG_TOTAL)
            total_reg = value & 'h1fff;
        else
            reserved_reg = value & 'h1fff;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(int total, int reserved);
        wait_idle();
        cfg_write(CFG_TOTAL, total);
        cfg_write(CFG_RESERVED, reserved);
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset values, every operation, field extremes, first fit around a hole.
    task automatic test_directed_ops();
        send_req(OP_ALLOC, 0, 1);            // map all used after reset: no fit
        send_req(OP_FREE, 4095, 2);          // runs past the end
        send_req(OP_ALLOC, 0, 0);            // zero count
        send_req(OP_INIT, 4095, 8191);       // init ignores its fields
        send_req(OP_ALLOC, 0, 4097);         // longer than the map
        send_req(OP_ALLOC, 0, 4096);         // block 0 is reserved: no fit
        send_req(OP_MARK, 100, 5);
        send_req(OP_ALLOC, 0, 200);          // skips the marked hole, lands at 105
        send_req(OP_ALLOC, 0, 99);           // fills 1..99 exactly
        send_req(OP_FREE, 0, 4096);          // whole map
        send_req(OP_ALLOC, 0, 4096);         // whole map at block 0
        send_req(OP_FREE, 4095, 1);          // last block
        send_req(OP_MARK, 4095, 1);
        send_req(OP_MARK, 4095, 1);          // already used: count must not move
        send_req(OP_FREE, 2048, 2048);
        send_req(OP_ALLOC, 0, 8191);         // every count bit set
        wait_idle();
    endtask

    // Register corners: small map, stale blocks, oversized total, reserved past total.
    task automatic test_config_edges();
        set_config(40, 3);
        send_req(OP_INIT, 0, 0);
        send_req(OP_ALLOC, 0, 38);           // fits the total but not the free run
        send_req(OP_ALLOC, 0, 37);
        send_req(OP_FREE, 30, 10);           // ends exactly at the total
        send_req(OP_FREE, 31, 10);           // one past the total
        // shrink without init: clear blocks above the total still count as free
        set_config(8, 3);
        send_req(OP_ALLOC, 0, 5);
        send_req(OP_FREE, 0, 8);
        set_config(8191, 0);                 // acts as the full map
        send_req(OP_INIT, 0, 0);
        send_req(OP_ALLOC, 0, 4096);
        set_config(100, 4096);               // reserved beyond total: init keeps all used
        send_req(OP_INIT, 0, 0);
        set_config(1, 8191);
        send_req(OP_INIT, 0, 0);
        set_config(1, 0);
        send_req(OP_INIT, 0, 0);
        send_req(OP_ALLOC, 0, 1);
        send_req(OP_ALLOC, 0, 1);
        set_config(0, 0);                    // empty map: everything is out of range
        send_req(OP_MARK, 0, 1);
        send_req(OP_INIT, 0, 0);
        wait_idle();
    endtask

    // Result side holds off long enough that the block stops taking items.
    task automatic test_backpressure();
        set_config(MAX_BLOCKS, 1);
        send_req(OP_INIT, 0, 0);
        wait_idle();
        hold_cycles = HOLD_CYCLES;
        repeat (5)
            send_req(OP_ALLOC, 0, $urandom_range(1, 300));
        send_req(OP_FREE, 1, 64);
        wait_idle();
    endtask

    // Mostly sensible traffic with random content: allocs, frees of granted runs,
    // marks inside the map, occasional init, and some raw noise.
    task automatic test_random_traffic(int n_items, int total, int reserved, bit no_gaps);
        block_run_t run;
        int         lim;
        int         r;
        int         k;
        int         s;
        int         c;
        set_config(total, reserved);
        quiet = no_gaps;
        send_req(OP_INIT, 0, 0);
        lim = effective_total();
        repeat (n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
                send_req(OP_INIT, $urandom_range(0, 4095), $urandom_range(0, 8191));
            else if (r < 48)
            begin
                k = $urandom_range(0, 99);
                if (k < 70)
                    c = $urandom_range(1, 8);
                else if (k < 92)
                    c = $urandom_range(1, 64);
                else
                    c = $urandom_range(1, lim);
                send_req(OP_ALLOC, $urandom_range(0, 4095), c);
            end
            else if (r < 72)
            begin
                if (granted_runs.size() > 0 && $urandom_range(0, 9) != 0)
                begin
                    k   = $urandom_range(0, granted_runs.size() - 1);
                    run = granted_runs[k];
                    granted_runs.delete(k);
                    c = ($urandom_range(0, 3) == 0) ? $urandom_range(1, run.len) : run.len;
                    send_req(OP_FREE, run.first, c);
                end
                else
                begin
                    s = $urandom_range(0, lim - 1);
                    send_req(OP_FREE, s, $urandom_range(1, lim - s));
                end
            end
            else if (r < 86)
            begin
                s = $urandom_range(0, lim - 1);
                send_req(OP_MARK, s, $urandom_range(1, (lim - s < 16) ? lim - s : 16));
            end
            else
                send_req(op_t'($urandom_range(0, 3)), $urandom_range(0, 4095),
                         $urandom_range(0, 8191));
        end
        wait_idle();
        quiet = 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        int t;
        errors       = 0;
        quiet        = 1'b0;
        hold_cycles  = 0;
        usage_bits   = '1;
        used_blocks  = MAX_BLOCKS;
        total_reg    = MAX_BLOCKS;
        reserved_reg = 1;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_TOTAL;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_ALLOC;
        req_ch.start_block <= '0;
        req_ch.block_count <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_config_edges();
        test_backpressure();

        test_random_traffic(150, MAX_BLOCKS, 1, 1'b0);
        t = $urandom_range(1, MAX_BLOCKS);
        test_random_traffic(120, t, $urandom_range(0, t + 8), 1'b0);
        test_random_traffic(100, 8191, 0, 1'b1);          // long stretch with no gaps
        test_random_traffic(100, 37, 2, 1'b0);
        t = $urandom_range(1, MAX_BLOCKS);
        test_random_traffic(90, t, $urandom_range(0, 64), 1'b0);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

        if (errors == 0)
            $display("PASS bitmap_block_allocator");
        else
            $display("FAIL bitmap_block_allocator");
        $finish;
    end

endmodule
